>>> rtl/core/sfr_pkg.sv
// Shared types, constants and helpers for the streaming find-and-replace block.
// Used by sfr_front, sfr_queue, sfr_back and stream_find_and_replace.
`default_nettype none

package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int MAX_RESULTS = 8;
  localparam int WIN_W       = MAX_PATTERN * BYTE_W;
  localparam int JOB_W       = MAX_RESULTS * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES      = 2'd0,
    CFG_PATTERN_LENGTH     = 2'd1,
    CFG_REPLACEMENT_BYTES  = 2'd2,
    CFG_REPLACEMENT_LENGTH = 2'd3
  } sfr_cfg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;
  } sfr_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_empty;
    logic              out_last;
  } sfr_out_t;

  // One queue entry: the results that one input beat causes, first byte in bits 7:0.
  typedef struct packed {
    logic [JOB_W-1:0] data;
    logic [LEN_W-1:0] count;
    logic             empty;
    logic             last;
  } sfr_job_t;

  function automatic logic [LEN_W-1:0] pat_len_sat(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (len == '0) r = LEN_W'(1);
    else if (len > LEN_W'(MAX_PATTERN)) r = LEN_W'(MAX_PATTERN);
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] repl_len_sat(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] r;
    r = len;
    if (len > LEN_W'(MAX_REPLACEMENT)) r = LEN_W'(MAX_REPLACEMENT);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfr_front.sv
// Front end: configuration registers, match window and per-beat classification.
// Depends on sfr_pkg; pushes one job per beat that yields results.
`default_nettype none

module sfr_front
  import sfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire sfr_in_t               in_data,
  input  wire logic                  q_full,
  output      logic                  push,
  output      sfr_job_t              push_job
);

  logic [WIN_W-1:0]      pat_r;
  logic [LEN_W-1:0]      plen_r;
  logic [JOB_W-1:0]      rep_r;
  logic [LEN_W-1:0]      rlen_r;
  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [LEN_W-1:0]      fill_r, fill_nxt;
  logic [WIN_W-1:0]      cand;
  logic [LEN_W-1:0]      nfill;
  logic                  hit;
  logic                  full;
  logic                  fire;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign nfill    = fill_r + LEN_W'(1);
  assign full     = (nfill >= plen_r);

  // The new byte lands just after the held bytes; all held bytes compare in parallel.
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      cand[i*BYTE_W +: BYTE_W] = (LEN_W'(i) == fill_r) ? in_data.in_byte
                                                        : win_r[i*BYTE_W +: BYTE_W];
      if ((LEN_W'(i) < plen_r) &&
          (cand[i*BYTE_W +: BYTE_W] != pat_r[i*BYTE_W +: BYTE_W])) begin
        hit = 1'b0;
      end
    end
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    push     = 1'b0;
    push_job = '0;
    if (fire) begin
      if (full && hit) begin
        fill_nxt       = '0;
        push_job.data  = rep_r;
        push_job.count = rlen_r;
        push_job.last  = in_data.in_last;
        push           = (rlen_r != '0) || in_data.in_last;
        // A deleted match at the end of the stream still needs an end marker.
        if (in_data.in_last && (rlen_r == '0)) begin
          push_job.data  = '0;
          push_job.count = LEN_W'(1);
          push_job.empty = 1'b1;
        end
      end else if (in_data.in_last) begin
        // Whatever the window holds, including the new byte, goes out now.
        push_job.data  = JOB_W'(cand);
        push_job.count = nfill;
        push_job.last  = 1'b1;
        push           = 1'b1;
        fill_nxt       = '0;
      end else if (full) begin
        push_job.data  = JOB_W'(cand[BYTE_W-1:0]);
        push_job.count = LEN_W'(1);
        push           = 1'b1;
        win_nxt        = cand >> BYTE_W;
        fill_nxt       = fill_r;
      end else begin
        win_nxt  = cand;
        fill_nxt = nfill;
      end
    end
    // Writing the pattern length discards the held bytes.
    if (cfg_we && (cfg_index == CFG_PATTERN_LENGTH)) fill_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      plen_r <= LEN_W'(1);
      rep_r  <= '0;
      rlen_r <= '0;
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PATTERN_BYTES:      pat_r  <= cfg_wdata[WIN_W-1:0];
          CFG_PATTERN_LENGTH:     plen_r <= pat_len_sat(cfg_wdata[LEN_W-1:0]);
          CFG_REPLACEMENT_BYTES:  rep_r  <= cfg_wdata[JOB_W-1:0];
          CFG_REPLACEMENT_LENGTH: rlen_r <= repl_len_sat(cfg_wdata[LEN_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

`ifndef ASSERT_OFF
  a_fill_below_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < plen_r)
    else $error("window holds a full pattern length between beats");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sfr_queue.sv
// Short job queue between the front end and the result expander.
// Depends on sfr_pkg for the job type and depth.
`default_nettype none

module sfr_queue
  import sfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire sfr_job_t push_job,
  output      logic     full,
  input  wire logic     pop,
  output      logic     q_valid,
  output      sfr_job_t q_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sfr_job_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");
  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("job popped from an empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/core/sfr_back.sv
// Result expander: takes jobs from the queue and sends their bytes out one beat at a time.
// Depends on sfr_pkg for the job and result types.
`default_nettype none

module sfr_back
  import sfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire sfr_job_t q_job,
  output      logic     pop,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      sfr_out_t out_data
);

  logic             busy_r, busy_nxt;
  logic [JOB_W-1:0] data_r, data_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             empty_r, empty_nxt;
  logic             last_r, last_nxt;
  logic             final_beat;

  // The next job loads in the same cycle as the final beat of the current one.
  assign final_beat = busy_r && out_ready && (rem_r == LEN_W'(1));
  assign pop        = q_valid && (!busy_r || final_beat);

  always_comb begin
    busy_nxt  = busy_r;
    data_nxt  = data_r;
    rem_nxt   = rem_r;
    empty_nxt = empty_r;
    last_nxt  = last_r;
    if (pop) begin
      busy_nxt  = 1'b1;
      data_nxt  = q_job.data;
      rem_nxt   = q_job.count;
      empty_nxt = q_job.empty;
      last_nxt  = q_job.last;
    end else if (busy_r && out_ready) begin
      busy_nxt = (rem_r != LEN_W'(1));
      data_nxt = data_r >> BYTE_W;
      rem_nxt  = rem_r - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    empty_r <= empty_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid          = busy_r;
  assign out_data.out_byte  = data_r[BYTE_W-1:0];
  assign out_data.out_empty = empty_r;
  assign out_data.out_last  = last_r && (rem_r == LEN_W'(1));

`ifndef ASSERT_OFF
  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0) && (rem_r <= LEN_W'(MAX_RESULTS)))
    else $error("result count out of range");
  a_empty_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && empty_r) |-> (rem_r == LEN_W'(1)) && last_r)
    else $error("end marker is not the only, final result");
`endif

endmodule

`default_nettype wire

>>> rtl/core/stream_find_and_replace.sv
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
`default_nettype none

// One input byte is accepted per cycle whenever the four-entry job queue has room;
// the pattern compare against the held window is done in the cycle of acceptance.
// Each input beat yields 0 to 8 result beats, which leave one per cycle while
// out_ready is high, so the sustained rate is one byte per cycle while beats
// average at most one result each; the queue absorbs a replacement burst of n
// bytes, stalling the input only once four jobs are waiting. The first result
// of a beat is registered in the queue, then in the expander. Configuration
// writes take effect at once and must be made while the block is idle.
module stream_find_and_replace
  import sfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire sfr_in_t               in_data,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      sfr_out_t              out_data
);

  logic     push;
  sfr_job_t push_job;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  sfr_job_t q_job;

  sfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  sfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
